### design/frt_pkg.sv
// frt_pkg: shared types, codes and constants of the fragment reassembly tracker
// no dependencies; imported by every other design file
`default_nettype none

package frt_pkg;

    // field widths
    localparam int unsigned SEQ_W   = 8;
    localparam int unsigned FLEN_W  = 16;
    localparam int unsigned PLEN_W  = 17;
    localparam int unsigned SLACK_W = 8;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    // reset values of the configuration registers
    localparam logic [SLACK_W-1:0] SLACK_RESET = 8'd16;
    localparam logic               COPY_RESET  = 1'b1;

    // saturation limit of the assembled length
    localparam logic [PLEN_W-1:0] PLEN_MAX = {PLEN_W{1'b1}};

    // default depth of the front-to-back queue
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROOM_SLACK = 2'd0,
        REG_COPY_MODE  = 2'd1
    } t_reg_idx;

    // fragment position codes
    typedef enum logic [1:0] {
        FLAG_MIDDLE = 2'd0,
        FLAG_LAST   = 2'd1,
        FLAG_FIRST  = 2'd2,
        FLAG_WHOLE  = 2'd3
    } t_flag;

    // action codes
    typedef enum logic [2:0] {
        ACT_PASS      = 3'd0,
        ACT_FIRST     = 3'd1,
        ACT_APPEND    = 3'd2,
        ACT_DELIVER   = 3'd3,
        ACT_DROP      = 3'd4,
        ACT_DROP_BOTH = 3'd5
    } t_action;

    // input item
    typedef struct packed {
        logic [1:0]        frag_pos;
        logic [SEQ_W-1:0]  frag_seq;
        logic [FLEN_W-1:0] frag_len;
        logic [FLEN_W-1:0] total_len;
    } t_frag_in;

    // result item
    typedef struct packed {
        logic [2:0]        action;
        logic              aborted_previous;
        logic [PLEN_W-1:0] packet_len;
    } t_frag_out;

    // classified fragment, front to back
    typedef struct packed {
        t_flag             kind;
        logic [SEQ_W-1:0]  seq;
        logic              seq_zero;
        logic [FLEN_W-1:0] flen;
        logic [PLEN_W-1:0] first_room;
    } t_cls;

    // configuration seen by front and back
    typedef struct packed {
        logic [SLACK_W-1:0] room_slack;
        logic               copy_mode;
    } t_cfg;

endpackage

`default_nettype wire

### design/frt_if.sv
// frt_in_if / frt_out_if: valid-ready channels of the tracker
// depends on frt_pkg for the payload types
`default_nettype none

interface frt_in_if import frt_pkg::*; ();
    logic     valid;
    logic     ready;
    t_frag_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface frt_out_if import frt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_frag_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/frt_front.sv
// frt_front: accepts fragment headers, classifies them, computes first-fragment room
// depends on frt_pkg; feeds frt_queue
`default_nettype none

module frt_front import frt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_frag_in i_data,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_cls          o_data
);

    logic              r_valid;
    t_cls              r_data;
    t_cls              n_data;
    logic [PLEN_W-1:0] room_sum;

    // stage register frees when empty or drained this cycle
    assign o_ready = !r_valid || i_ready;

    // classify and precompute room for a first fragment
    always_comb begin
        room_sum          = PLEN_W'(i_data.total_len) + PLEN_W'(i_cfg.room_slack);
        n_data.kind       = t_flag'(i_data.frag_pos);
        n_data.seq        = i_data.frag_seq;
        n_data.seq_zero   = (i_data.frag_seq == '0);
        n_data.flen       = i_data.frag_len;
        if (room_sum > PLEN_W'(i_data.frag_len)) begin
            n_data.first_room = room_sum - PLEN_W'(i_data.frag_len);
        end else begin
            n_data.first_room = '0;
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

### design/frt_queue.sv
// frt_queue: short fifo of classified fragments between front and back
// depends on frt_pkg for the entry type
`default_nettype none

module frt_queue import frt_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_cls i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_cls      o_data
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### design/frt_back.sv
// frt_back: reassembly state, sequence and room checks, result register
// depends on frt_pkg; fed by frt_queue
`default_nettype none

module frt_back import frt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_cls i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_frag_out o_data
);

    logic              r_assembling;
    logic [SEQ_W-1:0]  r_last_seq;
    logic [PLEN_W-1:0] r_room_left;
    logic [PLEN_W-1:0] r_asm_len;
    logic              r_out_valid;
    t_frag_out         r_out;

    logic              n_assembling;
    logic [SEQ_W-1:0]  n_last_seq;
    logic [PLEN_W-1:0] n_room_left;
    logic [PLEN_W-1:0] n_asm_len;
    t_frag_out         n_out;

    logic              take;
    logic [SEQ_W:0]    seq_expect;
    logic              seq_ok;
    logic              room_bad;
    logic [PLEN_W-1:0] room_sub;
    logic [PLEN_W:0]   asm_sum;
    logic [PLEN_W-1:0] asm_sat;

    // result register frees when empty or taken this cycle
    assign o_ready = !r_out_valid || i_ready;
    assign take    = i_valid && o_ready;

    // checks and saturating updates
    always_comb begin
        seq_expect = {1'b0, r_last_seq} + 1'b1;
        seq_ok     = ({1'b0, i_data.seq} == seq_expect);
        room_bad   = i_cfg.copy_mode && (PLEN_W'(i_data.flen) > r_room_left);
        room_sub   = (r_room_left > PLEN_W'(i_data.flen))
                     ? r_room_left - PLEN_W'(i_data.flen) : '0;
        asm_sum    = (PLEN_W + 1)'(r_asm_len) + (PLEN_W + 1)'(i_data.flen);
        asm_sat    = (asm_sum > (PLEN_W + 1)'(PLEN_MAX)) ? PLEN_MAX : asm_sum[PLEN_W-1:0];
    end

    // next state and result
    always_comb begin
        n_assembling           = r_assembling;
        n_last_seq             = r_last_seq;
        n_room_left            = r_room_left;
        n_asm_len              = r_asm_len;
        n_out.action           = ACT_DROP;
        n_out.aborted_previous = 1'b0;
        n_out.packet_len       = '0;
        unique case (i_data.kind)
            FLAG_WHOLE: begin
                n_out.action     = ACT_PASS;
                n_out.packet_len = PLEN_W'(i_data.flen);
            end
            FLAG_FIRST: begin
                n_out.aborted_previous = r_assembling;
                if (i_data.seq_zero) begin
                    n_assembling = 1'b1;
                    n_last_seq   = '0;
                    n_room_left  = i_data.first_room;
                    n_asm_len    = PLEN_W'(i_data.flen);
                    n_out.action = ACT_FIRST;
                end else begin
                    n_assembling = 1'b0;
                    n_out.action = ACT_DROP;
                end
            end
            FLAG_MIDDLE, FLAG_LAST: begin
                if (!r_assembling) begin
                    n_out.action = ACT_DROP;
                end else if (!seq_ok || room_bad) begin
                    n_out.action = ACT_DROP_BOTH;
                    n_assembling = 1'b0;
                end else begin
                    n_last_seq  = i_data.seq;
                    n_room_left = room_sub;
                    n_asm_len   = asm_sat;
                    if (i_data.kind == FLAG_LAST) begin
                        n_out.action     = ACT_DELIVER;
                        n_out.packet_len = asm_sat;
                        n_assembling     = 1'b0;
                    end else begin
                        n_out.action = ACT_APPEND;
                    end
                end
            end
            default: begin
                n_out.action = ACT_DROP;
            end
        endcase
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_assembling <= 1'b0;
            r_last_seq   <= '0;
            r_room_left  <= '0;
            r_asm_len    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (take) begin
                r_assembling <= n_assembling;
                r_last_seq   <= n_last_seq;
                r_room_left  <= n_room_left;
                r_asm_len    <= n_asm_len;
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

### design/fragment_reassembly_tracker_unit.sv
// fragment_reassembly_tracker_unit: one action result per fragment header
// path from input transfer to result valid: front stage register, queue entry,
// back result register; throughput one header per cycle while the result output
// is not stalled
// synchronous active-low reset clears the tracker state, the queue and the
// configuration registers (slack 16, copy mode on); ready right after reset
`default_nettype none

module fragment_reassembly_tracker_unit import frt_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    frt_in_if.sink                     i_frag,
    frt_out_if.source                  o_result
);

    logic [SLACK_W-1:0] r_room_slack;
    logic               r_copy_mode;
    t_cfg               cfg;

    logic f_valid;
    logic f_ready;
    t_cls f_data;
    logic q_valid;
    logic q_ready;
    t_cls q_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_room_slack <= SLACK_RESET;
            r_copy_mode  <= COPY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROOM_SLACK: r_room_slack <= i_cfg_data[SLACK_W-1:0];
                REG_COPY_MODE:  r_copy_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg.room_slack = r_room_slack;
    assign cfg.copy_mode  = r_copy_mode;

    frt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_frag.valid),
        .o_ready (i_frag.ready),
        .i_data  (i_frag.data),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_data  (f_data)
    );

    frt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_data),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    frt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_data  (q_data),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_data  (o_result.data)
    );

endmodule

`default_nettype wire
